// ===== src/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the Poisson CUSUM change detector
// Holds the item payloads, the state machine encodings, the register indexes
// and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Input item: command and observed count.
  typedef struct packed {
    logic        command;
    logic [15:0] sample_value;
  } pcd_in_t;

  // Result item.
  typedef struct packed {
    logic        alarm;
    logic        evaluated;
    logic [39:0] statistic;
  } pcd_out_t;

  // Commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_CHANGE_AMOUNT   = 1'b0;
  localparam logic CFG_ALARM_THRESHOLD = 1'b1;

  // Register reset values.
  localparam logic signed [16:0] CHANGE_AMOUNT_RST   = 17'sd256;
  localparam logic        [31:0] ALARM_THRESHOLD_RST = 32'd327680;

  // ln(2) in Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Saturation limits.
  localparam logic [47:0] SUM_MAX  = {48{1'b1}};
  localparam logic [31:0] CNT_MAX  = {32{1'b1}};
  localparam logic [39:0] STAT_MAX = {40{1'b1}};

  // Sequencer of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CHECK,
    ST_LOG_AFTER,
    ST_LOG_BEFORE,
    ST_SCALE,
    ST_WEIGHT,
    ST_ACCUM,
    ST_STAT,
    ST_DONE
  } pcd_state_e;

  // Sequencer of the logarithm unit.
  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQUARE,
    LG_FIX
  } pcd_lg_state_e;

endpackage

// ===== src/pcd_stream_if.sv =====
// ----------------------------------------------------------------------------
// pcd_stream_if: valid/ready channel
// Carries one item of the given payload type per accepted handshake.
// ----------------------------------------------------------------------------
interface pcd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/pcd_log2.sv =====
// ----------------------------------------------------------------------------
// pcd_log2: iterative base-2 logarithm
// Normalizes a 64-bit fixed-point value by shifting, then builds the fraction
// one bit per squaring of a Q1.30 mantissa on a single shared multiplier.
// ----------------------------------------------------------------------------
module pcd_log2 import pcd_pkg::*; #(
  parameter int FracBits = 16,
  localparam int LW      = FracBits + 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          value_i,
  output logic                 done_o,
  output logic signed [LW-1:0] result_o
);

  localparam int IW = $clog2(FracBits);

  pcd_lg_state_e        state_q, state_d;
  logic [63:0]          norm_q, norm_d;
  logic [5:0]           pos_q, pos_d;
  logic [30:0]          man_q, man_d;
  logic [61:0]          sqr_q, sqr_d;
  logic [FracBits-1:0]  frac_q, frac_d;
  logic [IW-1:0]        iter_q, iter_d;
  logic                 done_q, done_d;
  logic [31:0]          scaled;
  logic [7:0]           int_part;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
    pos_q  <= pos_d;
    man_q  <= man_d;
    sqr_q  <= sqr_d;
    frac_q <= frac_d;
    iter_q <= iter_d;
  end

  assign scaled = sqr_q[61:30];

  // Sequencer: normalize, then square and renormalize once per fraction bit.
  always_comb begin
    state_d = state_q;
    norm_d  = norm_q;
    pos_d   = pos_q;
    man_d   = man_q;
    sqr_d   = sqr_q;
    frac_d  = frac_q;
    iter_d  = iter_q;
    done_d  = 1'b0;
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          norm_d  = (value_i == 64'd0) ? 64'd1 : value_i;
          pos_d   = 6'd63;
          state_d = LG_NORM;
        end
      end
      LG_NORM: begin
        if (norm_q[63]) begin
          man_d   = norm_q[63:33];
          frac_d  = '0;
          iter_d  = '0;
          state_d = LG_SQUARE;
        end else if (norm_q[63:56] == 8'd0) begin
          norm_d = norm_q << 8;
          pos_d  = pos_q - 6'd8;
        end else begin
          norm_d = norm_q << 1;
          pos_d  = pos_q - 6'd1;
        end
      end
      LG_SQUARE: begin
        sqr_d   = 62'(man_q) * 62'(man_q);
        state_d = LG_FIX;
      end
      LG_FIX: begin
        if (scaled[31]) begin
          man_d = scaled[31:1];
        end else begin
          man_d = scaled[30:0];
        end
        frac_d = {frac_q[FracBits-2:0], scaled[31]};
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(FracBits - 1)) begin
          done_d  = 1'b1;
          state_d = LG_IDLE;
        end else begin
          state_d = LG_SQUARE;
        end
      end
      default: state_d = LG_IDLE;
    endcase
  end

  // Integer part is the leading-one position less the fraction width.
  assign int_part = {2'b00, pos_q} - 8'(FracBits);
  assign result_o = $signed({int_part, frac_q});
  assign done_o   = done_q;

endmodule

// ===== src/poisson_cusum_change_detector_top.sv =====
// ----------------------------------------------------------------------------
// poisson_cusum_change_detector_top: Poisson CUSUM change detector
// Running mean of a count stream, Poisson log-likelihood ratio test against a
// shifted mean, and an alarm on the CUSUM statistic.
// ----------------------------------------------------------------------------
// One item is worked at a time and the input is not ready meanwhile. A clear
// item goes straight to the done state. A sample item is accepted, passes the
// bit-serial divider that forms the mean and a check state, then runs the
// shared logarithm unit twice (each run does normalizing shifts, then a
// squaring and a fixing step per fraction bit, then a handoff), then the
// scale, weight, accumulate and statistic states, and the done state loads
// the output register once it is free.
// An item whose shifted mean is below one leaves right after the check.
// A finished result waits in an output register, so the next item can be
// accepted while it is still unread.
// ----------------------------------------------------------------------------
module poisson_cusum_change_detector_top import pcd_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcd_stream_if.sink   sample_if,
  pcd_stream_if.source result_if,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int LW  = FRACTION_BITS + 8;
  localparam int SHR = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int SHL = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;

  pcd_state_e state_q, state_d;

  // Configuration.
  logic signed [16:0] change_q;
  logic [31:0]        thresh_q;

  // Detector state.
  logic [31:0]        count_q, count_d;
  logic [47:0]        sum_q, sum_d;
  logic signed [47:0] lik_q, lik_d;
  logic signed [47:0] min_q, min_d;

  // Divider.
  logic [31:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [32:0] rem_shift;
  logic [32:0] trial;

  // Likelihood datapath.
  logic [15:0]          sample_q, sample_d;
  logic signed [63:0]   after_q, after_d;
  logic signed [63:0]   before_q, before_d;
  logic signed [LW-1:0] la_q, la_d;
  logic                 dneg_q, dneg_d;
  logic [LW-1:0]        mag_q, mag_d;
  logic [LW+31:0]       prod1_q, prod1_d;
  logic [LW+15:0]       prod2_q, prod2_d;
  logic signed [LW:0]   dl;
  logic [LW+32:0]       ln_round;
  logic [LW+16:0]       term_round;
  logic [65:0]          term_ext;
  logic signed [65:0]   acc;
  logic signed [47:0]   acc_sat;
  logic signed [63:0]   change_ext;
  logic [48:0]          sum_add;

  // Statistic.
  logic [47:0] diff;
  logic [63:0] diff_scaled;
  logic [39:0] cur_stat;

  // Pending result and output register.
  logic        res_alarm_q, res_alarm_d;
  logic        res_eval_q, res_eval_d;
  logic [39:0] res_stat_q, res_stat_d;
  logic        out_valid_q, out_valid_d;
  pcd_out_t    out_data_q, out_data_d;

  // Logarithm unit.
  logic                 log_start;
  logic [63:0]          log_val;
  logic                 log_done;
  logic signed [LW-1:0] log_res;

  pcd_log2 #(
    .FracBits (FRACTION_BITS)
  ) u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .value_i  (log_val),
    .done_o   (log_done),
    .result_o (log_res)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_q <= CHANGE_AMOUNT_RST;
      thresh_q <= ALARM_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANGE_AMOUNT:   change_q <= $signed(cfg_wdata_i[16:0]);
        CFG_ALARM_THRESHOLD: thresh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      lik_q       <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      lik_q       <= lik_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dcnt_q      <= dcnt_d;
    sample_q    <= sample_d;
    after_q     <= after_d;
    before_q    <= before_d;
    la_q        <= la_d;
    dneg_q      <= dneg_d;
    mag_q       <= mag_d;
    prod1_q     <= prod1_d;
    prod2_q     <= prod2_d;
    res_alarm_q <= res_alarm_d;
    res_eval_q  <= res_eval_d;
    res_stat_q  <= res_stat_d;
    out_data_q  <= out_data_d;
  end

  // Statistic from the current sum and minimum, rescaled to Q24.16.
  assign diff        = lik_q - min_q;
  assign diff_scaled = (64'(diff) >> SHR) << SHL;
  assign cur_stat    = (diff_scaled > 64'(STAT_MAX)) ? STAT_MAX : diff_scaled[39:0];

  // One restoring divider step.
  assign rem_shift = {rem_q, quo_q[63]};
  assign trial     = rem_shift - {1'b0, count_q};

  // Shifted-mean term and the log ratio chain.
  assign change_ext = 64'(change_q) <<< (FRACTION_BITS - 8);
  assign sum_add    = {1'b0, sum_q} + 49'(sample_if.data.sample_value);
  assign dl         = (LW+1)'(la_q) - (LW+1)'(log_res);
  assign ln_round   = {1'b0, prod1_q} + (LW+33)'(33'h080000000);
  assign term_round = {1'b0, prod2_q} + (LW+17)'(128);
  assign term_ext   = dneg_q ? -(66'(term_round[LW+15:8])) : 66'(term_round[LW+15:8]);
  assign acc        = 66'(lik_q) + 66'(before_q - after_q) + $signed(term_ext);
  assign acc_sat    = (acc > 66'sh07FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
                      (acc < -66'sh0800000000000) ? 48'sh800000000000 : acc[47:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    lik_d       = lik_q;
    min_d       = min_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    sample_d    = sample_q;
    after_d     = after_q;
    before_d    = before_q;
    la_d        = la_q;
    dneg_d      = dneg_q;
    mag_d       = mag_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    res_alarm_d = res_alarm_q;
    res_eval_d  = res_eval_q;
    res_stat_d  = res_stat_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & ~result_if.ready;
    log_start   = 1'b0;
    log_val     = before_q;

    case (state_q)
      ST_IDLE: begin
        if (sample_if.valid) begin
          if (sample_if.data.command == CMD_CLEAR) begin
            count_d     = '0;
            sum_d       = '0;
            lik_d       = '0;
            min_d       = '0;
            res_alarm_d = 1'b0;
            res_eval_d  = 1'b0;
            res_stat_d  = '0;
            state_d     = ST_DONE;
          end else begin
            count_d  = (count_q == CNT_MAX) ? count_q : count_q + 32'd1;
            sum_d    = sum_add[48] ? SUM_MAX : sum_add[47:0];
            sample_d = sample_if.data.sample_value;
            rem_d    = '0;
            quo_d    = 64'(sum_d) << (FRACTION_BITS - 8);
            dcnt_d   = '0;
            state_d  = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (trial[32]) begin
          rem_d = rem_shift[31:0];
        end else begin
          rem_d = trial[31:0];
        end
        quo_d  = {quo_q[62:0], ~trial[32]};
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        after_d  = $signed(quo_q) + change_ext;
        before_d = ($signed(quo_q) < 64'sd1) ? 64'sd1 : $signed(quo_q);
        if (after_d < (64'sd1 <<< FRACTION_BITS)) begin
          res_alarm_d = 1'b0;
          res_eval_d  = 1'b0;
          res_stat_d  = cur_stat;
          state_d     = ST_DONE;
        end else begin
          log_start = 1'b1;
          log_val   = after_d;
          state_d   = ST_LOG_AFTER;
        end
      end
      ST_LOG_AFTER: begin
        if (log_done) begin
          la_d      = log_res;
          log_start = 1'b1;
          state_d   = ST_LOG_BEFORE;
        end
      end
      ST_LOG_BEFORE: begin
        if (log_done) begin
          dneg_d  = dl[LW];
          mag_d   = dl[LW] ? LW'(-dl) : LW'(dl);
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod1_d = (LW+32)'(mag_q) * (LW+32)'(LN2_Q32);
        state_d = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        prod2_d = (LW+16)'(ln_round[LW+31:32]) * (LW+16)'(sample_q);
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        lik_d = acc_sat;
        if (acc_sat < min_q) begin
          min_d = acc_sat;
        end
        state_d = ST_STAT;
      end
      ST_STAT: begin
        res_alarm_d = (cur_stat > 40'(thresh_q));
        res_eval_d  = 1'b1;
        res_stat_d  = cur_stat;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || result_if.ready) begin
          out_valid_d          = 1'b1;
          out_data_d.alarm     = res_alarm_q;
          out_data_d.evaluated = res_eval_q;
          out_data_d.statistic = res_stat_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Ports.
  assign sample_if.ready = (state_q == ST_IDLE);
  assign result_if.valid = out_valid_q;
  assign result_if.data  = out_data_q;

  // An alarm is only raised on an evaluated step.
  a_alarm_evaluated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.alarm) |-> out_data_q.evaluated)
    else $error("alarm without likelihood update");

  // The tracked minimum never exceeds the running sum.
  a_min_le_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= lik_q)
    else $error("likelihood minimum above likelihood sum");

  // The divider never runs with a zero count.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (count_q != 32'd0))
    else $error("divide by zero count");

  // A result is loaded only from the done state.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside done state");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the Poisson CUSUM change detector
// Drives command items with random idling on both channels, predicts every
// result with a fixed-point model of the detector and checks each result item.
// ----------------------------------------------------------------------------

// Predicts detector results and keeps the queue of expected results.
class pcd_scoreboard;
  localparam int FB = 16;
  logic signed [16:0] change_amount;
  logic [31:0]        alarm_threshold;
  logic [31:0]        count_so_far;
  logic [47:0]        sum_so_far;
  longint             lik_sum;
  longint             lik_min;
  pcd_pkg::pcd_out_t  expected_q[$];
  int                 errors;

  function new();
    change_amount   = pcd_pkg::CHANGE_AMOUNT_RST;
    alarm_threshold = pcd_pkg::ALARM_THRESHOLD_RST;
    clear_state();
    errors = 0;
  endfunction

  function void clear_state();
    count_so_far = '0;
    sum_so_far   = '0;
    lik_sum      = 0;
    lik_min      = 0;
  endfunction

  function void write_reg(logic idx, logic [31:0] value);
    if (idx == pcd_pkg::CFG_CHANGE_AMOUNT) begin
      change_amount = value[16:0];
    end else begin
      alarm_threshold = value;
    end
  endfunction

  // Base-two logarithm of a positive fixed-point value by repeated squaring.
  function longint log2_fixed(logic [63:0] v);
    int          p;
    logic [63:0] m;
    longint      frac;
    if (v == 0) v = 1;
    p = 63;
    while (v[p] == 1'b0) p--;
    m = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
    frac = 0;
    for (int i = 1; i <= FB; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << (FB - i));
      end
    end
    return longint'(p - FB) * (longint'(1) << FB) + frac;
  endfunction

  function logic [39:0] statistic_now();
    logic [63:0] d;
    d = lik_sum - lik_min;
    return (d > 64'(pcd_pkg::STAT_MAX)) ? pcd_pkg::STAT_MAX : d[39:0];
  endfunction

  // Works out the result of one accepted input item.
  function void note_input(pcd_pkg::pcd_in_t item);
    pcd_pkg::pcd_out_t res;
    logic [63:0] s64, q, r, mag, sample;
    longint      mean, after, prior, dl, lnr, st;
    sample = item.sample_value;
    res = '0;
    if (item.command == pcd_pkg::CMD_CLEAR) begin
      clear_state();
    end else begin
      if (count_so_far != pcd_pkg::CNT_MAX) count_so_far++;
      s64 = 64'(sum_so_far) + sample;
      sum_so_far = (s64 > 64'(pcd_pkg::SUM_MAX)) ? pcd_pkg::SUM_MAX : s64[47:0];
      q = sum_so_far / count_so_far;
      r = sum_so_far % count_so_far;
      mean = longint'((q << (FB - 8)) + ((r << (FB - 8)) / count_so_far));
      after = mean + longint'(change_amount) * (longint'(1) << (FB - 8));
      if (after < (longint'(1) << FB)) begin
        res.statistic = statistic_now();
      end else begin
        prior = (mean < 1) ? 1 : mean;
        dl = log2_fixed(after) - log2_fixed(prior);
        mag = (dl < 0) ? -dl : dl;
        mag = (mag * 64'(pcd_pkg::LN2_Q32) + 64'h8000_0000) >> 32;
        mag = (mag * sample + 64'd128) >> 8;
        lnr = (dl < 0) ? -longint'(mag) : longint'(mag);
        st = lik_sum + (prior - after) + lnr;
        if (st > 64'sd140737488355327) st = 64'sd140737488355327;
        if (st < -64'sd140737488355328) st = -64'sd140737488355328;
        lik_sum = st;
        if (lik_sum < lik_min) lik_min = lik_sum;
        res.statistic = statistic_now();
        res.evaluated = 1'b1;
        res.alarm = (res.statistic > 40'(alarm_threshold));
      end
    end
    expected_q.push_back(res);
  endfunction

  // Compares one result item with the oldest expectation.
  function void check_result(pcd_pkg::pcd_out_t got);
    pcd_pkg::pcd_out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.alarm !== want.alarm || got.evaluated !== want.evaluated ||
        got.statistic !== want.statistic) begin
      $display("%0t: mismatch expected alarm %0d evaluated %0d statistic %h",
               $time, want.alarm, want.evaluated, want.statistic);
      $display("%0t:          actual alarm %0d evaluated %0d statistic %h",
               $time, got.alarm, got.evaluated, got.statistic);
      errors++;
    end
  endfunction
endclass

module tb;
  import pcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;

  pcd_stream_if #(.payload_t(pcd_in_t))  sample_if ();
  pcd_stream_if #(.payload_t(pcd_out_t)) result_if ();

  pcd_scoreboard detector_sb;

  poisson_cusum_change_detector_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_if  (sample_if),
    .result_if  (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, and each accepted item is checked.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      detector_sb.check_result(result_if.data);
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one item, with random idle cycles before it. The valid line stays
  // high after the accept until the next idle cycle or the next item.
  task automatic send_item(logic cmd, logic [15:0] value);
    pcd_in_t item;
    item.command = cmd;
    item.sample_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= item;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    detector_sb.note_input(item);
  endtask

  // Waits for all results, lets the block settle, then writes a register.
  task automatic write_reg(logic idx, logic [31:0] value);
    sample_if.valid <= 1'b0;
    while (detector_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    detector_sb.write_reg(idx, value);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(2048));
      2: return 16'($urandom_range(600, 300));
      default: return 16'($urandom_range(1500, 1000));
    endcase
  endfunction

  // A run of samples after a clear, with rare extra clears as noise.
  task automatic sample_burst(int n);
    send_item(CMD_CLEAR, 16'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_item(CMD_CLEAR, 16'($urandom));
      else send_item(CMD_SAMPLE, random_sample());
    end
  endtask

  initial begin
    logic signed [16:0] shifts[6];
    logic [31:0]        limits[6];
    detector_sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CHANGE_AMOUNT;
    cfg_wdata_i = '0;
    sample_if.valid = 1'b0;
    sample_if.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shifts = '{17'sd256, -17'sd65535, 17'sd65535, -17'sd128, 17'sd1, 17'sd64};
    limits = '{32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd327680, 32'd20000, 32'd1000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: field extremes, clears, skips and big samples.
    send_item(CMD_SAMPLE, 16'd0);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'd256);
    send_item(CMD_CLEAR, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'd1);
    send_item(CMD_SAMPLE, 16'd512);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_CLEAR, 16'd0);
    write_reg(CFG_CHANGE_AMOUNT, 32'(-17'sd65535));
    write_reg(CFG_ALARM_THRESHOLD, 32'd1);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'd0);
    send_item(CMD_CLEAR, 16'h5555);
    send_item(CMD_SAMPLE, 16'hAAAA);

    // Random phases across register settings and idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_CHANGE_AMOUNT, 32'(shifts[ph % 6]));
      write_reg(CFG_ALARM_THRESHOLD, limits[(ph + 1) % 6]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int b = 0; b < 4; b++) sample_burst(20);
    end

    // Drain and finish.
    sample_if.valid <= 1'b0;
    while (detector_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (detector_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/pcd_pkg.sv
src/pcd_stream_if.sv
src/pcd_log2.sv
src/poisson_cusum_change_detector_top.sv
sim/tb.sv
